// ===== sv/bced_pkg.sv =====
// Package: shared types and constants for the bounded complex distance block.
`timescale 1ns / 1ps

package bced_pkg;

   // Field and datapath widths
   localparam int ELEM_W  = 16;
   localparam int DIFF_W  = ELEM_W + 1;
   localparam int SQ_W    = 32;
   localparam int BOUND_W = 24;
   localparam int SUM_W   = 48;
   localparam int DIST_W  = 24;
   localparam int COUNT_W = 32;
   localparam int LEN_W   = 13;

   // Vector length limits and defaults
   localparam int MIN_LEN       = 8;
   localparam int RESET_LEN     = 8;
   localparam int DEF_BATCH_LEN = 120;
   localparam int DEF_MAX_LEN   = 4096;

   // Square root: one result bit per step
   localparam int SQRT_STEPS = DIST_W;
   localparam int REM_W      = DIST_W + 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DEC,
      ST_SQRT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_in;
      logic mul;
      logic acc;
      logic step;
      logic early;
      logic complete;
      logic sqrt_start;
      logic load_out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic skipping;
      logic last;
      logic batch_full;
      logic over_bound;
      logic sqrt_valid;
   } status_type;

endpackage

// ===== sv/bced_sqrt.sv =====
// Iterative floor square root of the 48-bit sum, one root bit per cycle.
`timescale 1ns / 1ps

module bced_sqrt
   import bced_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  radicand,
   output logic              valid,
   output logic [DIST_W-1:0] root
);

   localparam int STEP_W = $clog2(SQRT_STEPS);

   logic [SUM_W-1:0]  val_ff, val_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIST_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              valid_ff, valid_in;
   logic [REM_W-1:0]  rem_pre;
   logic [REM_W-1:0]  trial;

   // Bring down the next bit pair and form the trial value
   assign rem_pre = {rem_ff[REM_W-3:0], val_ff[SUM_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};

   // Load the radicand on start, else advance one restoring step while busy
   always_comb begin
      val_in   = val_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      if (start) begin
         val_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
         step_in  = '0;
         busy_in  = 1'b1;
         valid_in = 1'b0;
      end else if (busy_ff) begin
         val_in  = {val_ff[SUM_W-3:0], 2'b00};
         step_in = step_ff + STEP_W'(1);
         if (rem_pre >= trial) begin
            rem_in  = rem_pre - trial;
            root_in = {root_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_pre;
            root_in = {root_ff[DIST_W-2:0], 1'b0};
         end
         if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign valid = valid_ff;
   assign root  = root_ff;

endmodule

// ===== sv/bced_dp.sv =====
// Datapath: difference squares, running sum, bound check, counters and result register.
`timescale 1ns / 1ps

module bced_dp
   import bced_pkg::*;
#(
   parameter int BATCH_LEN = DEF_BATCH_LEN,
   parameter int MAX_LEN   = DEF_MAX_LEN
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         sts,
   input  logic               csr_we,
   input  logic [LEN_W-1:0]   csr_data,
   input  logic [ELEM_W-1:0]  a_re,
   input  logic [ELEM_W-1:0]  a_im,
   input  logic [ELEM_W-1:0]  b_re,
   input  logic [ELEM_W-1:0]  b_im,
   input  logic [BOUND_W-1:0] bound,
   output logic [DIST_W-1:0]  dist_res,
   output logic               early_exit,
   output logic [COUNT_W-1:0] completed_count
);

   localparam int BATCH_W = $clog2(BATCH_LEN);

   logic [LEN_W-1:0]          vlen_ff, vlen_in;
   logic signed [DIFF_W-1:0]  dr_ff, dr_in;
   logic signed [DIFF_W-1:0]  di_ff, di_in;
   logic [BOUND_W-1:0]        bnd_ff, bnd_in;
   logic                      first_ff, first_in;
   logic [SQ_W-1:0]           sqr_ff, sqr_in;
   logic [SQ_W-1:0]           sqi_ff, sqi_in;
   logic [SUM_W-1:0]          bound_sq_ff, bound_sq_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [LEN_W-1:0]          elem_index_ff, elem_index_in;
   logic [BATCH_W-1:0]        batch_ff, batch_in;
   logic                      skip_ff, skip_in;
   logic [COUNT_W-1:0]        done_count_ff, done_count_in;
   logic                      res_early_ff, res_early_in;
   logic [DIST_W-1:0]         dist_out_ff, dist_out_in;
   logic                      early_out_ff, early_out_in;
   logic [COUNT_W-1:0]        count_out_ff, count_out_in;

   logic signed [2*DIFF_W-1:0] prod_r;
   logic signed [2*DIFF_W-1:0] prod_i;
   logic [LEN_W-1:0]           len_w;
   logic [LEN_W-1:0]           count_w;
   logic                       first_w;
   logic                       last_w;
   logic                       batch_full_w;
   logic                       sqrt_valid;
   logic [DIST_W-1:0]          sqrt_root;

   // Clamp the programmed length into the legal range
   always_comb begin
      if (vlen_ff < LEN_W'(MIN_LEN)) begin
         len_w = LEN_W'(MIN_LEN);
      end else if (vlen_ff > LEN_W'(MAX_LEN)) begin
         len_w = LEN_W'(MAX_LEN);
      end else begin
         len_w = vlen_ff;
      end
   end

   assign first_w      = (elem_index_ff == '0);
   assign count_w      = elem_index_ff + LEN_W'(1);
   assign last_w       = (count_w >= len_w);
   assign batch_full_w = (batch_ff == BATCH_W'(BATCH_LEN - 1));

   assign prod_r = dr_ff * dr_ff;
   assign prod_i = di_ff * di_ff;

   // Next values of all datapath registers
   always_comb begin
      vlen_in       = vlen_ff;
      dr_in         = dr_ff;
      di_in         = di_ff;
      bnd_in        = bnd_ff;
      first_in      = first_ff;
      sqr_in        = sqr_ff;
      sqi_in        = sqi_ff;
      bound_sq_in   = bound_sq_ff;
      sum_in        = sum_ff;
      elem_index_in = elem_index_ff;
      batch_in      = batch_ff;
      skip_in       = skip_ff;
      done_count_in = done_count_ff;
      res_early_in  = res_early_ff;
      dist_out_in   = dist_out_ff;
      early_out_in  = early_out_ff;
      count_out_in  = count_out_ff;

      if (csr_we) begin
         vlen_in = csr_data;
      end

      // Capture the beat; a new vector drops any pending skip
      if (cmd.load_in) begin
         dr_in    = $signed({a_re[ELEM_W-1], a_re}) - $signed({b_re[ELEM_W-1], b_re});
         di_in    = $signed({a_im[ELEM_W-1], a_im}) - $signed({b_im[ELEM_W-1], b_im});
         bnd_in   = bound;
         first_in = first_w;
         if (first_w) begin
            skip_in = 1'b0;
         end
      end

      // Square the differences and, on a first element, the bound
      if (cmd.mul) begin
         sqr_in = prod_r[SQ_W-1:0];
         sqi_in = prod_i[SQ_W-1:0];
         if (first_ff) begin
            bound_sq_in = SUM_W'(bnd_ff) * SUM_W'(bnd_ff);
         end
      end

      // Accumulate unless the vector is being skipped
      if (cmd.acc && !skip_ff) begin
         sum_in = (first_ff ? '0 : sum_ff) + SUM_W'(sqr_ff) + SUM_W'(sqi_ff);
      end

      // Advance element and batch position
      if (cmd.step) begin
         res_early_in = cmd.early;
         if (last_w) begin
            elem_index_in = '0;
            batch_in      = '0;
            skip_in       = 1'b0;
         end else begin
            elem_index_in = count_w;
            batch_in      = batch_full_w ? '0 : batch_ff + BATCH_W'(1);
            if (cmd.early) begin
               skip_in = 1'b1;
            end
         end
         if (cmd.complete) begin
            done_count_in = done_count_ff + COUNT_W'(1);
         end
      end

      // Load the result register
      if (cmd.load_out) begin
         dist_out_in  = sqrt_root;
         early_out_in = res_early_ff;
         count_out_in = done_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff       <= LEN_W'(RESET_LEN);
         bound_sq_ff   <= '0;
         sum_ff        <= '0;
         elem_index_ff <= '0;
         batch_ff      <= '0;
         skip_ff       <= 1'b0;
         done_count_ff <= '0;
      end else begin
         vlen_ff       <= vlen_in;
         bound_sq_ff   <= bound_sq_in;
         sum_ff        <= sum_in;
         elem_index_ff <= elem_index_in;
         batch_ff      <= batch_in;
         skip_ff       <= skip_in;
         done_count_ff <= done_count_in;
      end
   end

   always_ff @(posedge clock) begin
      dr_ff        <= dr_in;
      di_ff        <= di_in;
      bnd_ff       <= bnd_in;
      first_ff     <= first_in;
      sqr_ff       <= sqr_in;
      sqi_ff       <= sqi_in;
      res_early_ff <= res_early_in;
      dist_out_ff  <= dist_out_in;
      early_out_ff <= early_out_in;
      count_out_ff <= count_out_in;
   end

   bced_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (sum_ff),
      .valid    (sqrt_valid),
      .root     (sqrt_root)
   );

   // Report status to the controller
   always_comb begin
      sts.skipping   = skip_ff;
      sts.last       = last_w;
      sts.batch_full = batch_full_w;
      sts.over_bound = (sum_ff > bound_sq_ff);
      sts.sqrt_valid = sqrt_valid;
   end

   assign dist_res        = dist_out_ff;
   assign early_exit      = early_out_ff;
   assign completed_count = count_out_ff;

endmodule

// ===== sv/bced_ctrl.sv =====
// Controller: sequences each beat through multiply, accumulate and decide, and a result beat through root.
`timescale 1ns / 1ps

module bced_ctrl
   import bced_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      early_w;
   logic      complete_w;

   // Early exit only on a batch boundary; completion only at vector end
   assign early_w    = !sts.skipping && sts.batch_full && sts.over_bound;
   assign complete_w = !sts.skipping && sts.last && !early_w;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            cmd.step       = 1'b1;
            cmd.early      = early_w;
            cmd.complete   = complete_w;
            cmd.sqrt_start = early_w || complete_w;
            state_in       = (early_w || complete_w) ? ST_SQRT : ST_IDLE;
         end
         ST_SQRT: begin
            // Hold until the root is ready and the result register is free
            if (sts.sqrt_valid && (!rsp_valid_ff || !rsp_stall)) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/bounded_complex_euclidean_distance.sv =====
// Top level: bounded complex Euclidean distance with early abandon.
//
//   port group  direction  handshake             payload
//   req_*       in         req_valid/req_stall   a_re, a_im, b_re, b_im, bound
//   rsp_*       out        rsp_valid/rsp_stall   dist_res, early_exit, completed_count
//   csr_*       in         csr_valid/csr_ready   vector_length
//
// An element beat steps through the controller states capture, square, accumulate
// and decide; a beat that yields a result goes on to the square root and then loads
// the result register. Reset is synchronous and clears all counters and the sum;
// vector_length returns to 8. The result register lets the next beat enter while a
// result is stalled; a new result waits until that register is free.
`timescale 1ns / 1ps

module bounded_complex_euclidean_distance
   import bced_pkg::*;
#(
   parameter int BATCH_LEN = DEF_BATCH_LEN,
   parameter int MAX_LEN   = DEF_MAX_LEN
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ELEM_W-1:0]  req_a_re,
   input  logic [ELEM_W-1:0]  req_a_im,
   input  logic [ELEM_W-1:0]  req_b_re,
   input  logic [ELEM_W-1:0]  req_b_im,
   input  logic [BOUND_W-1:0] req_bound,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DIST_W-1:0]  rsp_dist_res,
   output logic               rsp_early_exit,
   output logic [COUNT_W-1:0] rsp_completed_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LEN_W-1:0]   csr_vector_length
);

   cmd_type    cmd;
   status_type sts;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   bced_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bced_dp #(
      .BATCH_LEN (BATCH_LEN),
      .MAX_LEN   (MAX_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_we          (csr_valid && csr_ready),
      .csr_data        (csr_vector_length),
      .a_re            (req_a_re),
      .a_im            (req_a_im),
      .b_re            (req_b_re),
      .b_im            (req_b_im),
      .bound           (req_bound),
      .dist_res        (rsp_dist_res),
      .early_exit      (rsp_early_exit),
      .completed_count (rsp_completed_count)
   );

   // One beat at a time: an accepted beat closes the input until it is done
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input beat accepted while another was in flight");

   // The result register is loaded only from a finished root
   a_root_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.sqrt_valid)
      else $error("result loaded before square root finished");

   // A skipped vector never starts a root
   a_no_skip_result: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_start |-> !sts.skipping)
      else $error("result started for a skipped vector");

   // A new result never overwrites one still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

// ===== tb/bounded_complex_euclidean_distance_tb.sv =====
// Testbench for the bounded complex Euclidean distance block, self-checking.
`timescale 1ns / 1ps

module bounded_complex_euclidean_distance_tb
   import bced_pkg::*;
();

   // Cycles to let an element that gives no result clear the pipeline
   localparam int DRAIN_CYCLES = 40;
   // Beats sent by the random test
   localparam int RANDOM_PAIRS = 1050;

   typedef struct packed {
      logic [ELEM_W-1:0]  a_re;
      logic [ELEM_W-1:0]  a_im;
      logic [ELEM_W-1:0]  b_re;
      logic [ELEM_W-1:0]  b_im;
      logic [BOUND_W-1:0] bound;
   } pair_beat_type;

   typedef struct packed {
      logic [DIST_W-1:0]  root;
      logic               early;
      logic [COUNT_W-1:0] done_cnt;
   } dist_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [ELEM_W-1:0]  req_a_re;
   logic [ELEM_W-1:0]  req_a_im;
   logic [ELEM_W-1:0]  req_b_re;
   logic [ELEM_W-1:0]  req_b_im;
   logic [BOUND_W-1:0] req_bound;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [DIST_W-1:0]  rsp_dist_res;
   logic               rsp_early_exit;
   logic [COUNT_W-1:0] rsp_completed_count;
   logic               csr_valid;
   logic               csr_ready;
   logic [LEN_W-1:0]   csr_vector_length;

   // Predicted block state
   logic [LEN_W-1:0]   cfg_len     = LEN_W'(RESET_LEN);
   logic [SUM_W-1:0]   acc_sum     = '0;
   logic [LEN_W-1:0]   elem_idx    = '0;
   logic [SUM_W-1:0]   limit_sq    = '0;
   logic               abandoned   = 1'b0;
   logic [COUNT_W-1:0] done_total  = '0;

   dist_result_type expected_dists[$];
   int  mismatch_count  = 0;
   int  pairs_scored    = 0;
   bit  steady_flow     = 1'b0;

   bounded_complex_euclidean_distance i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_a_re            (req_a_re),
      .req_a_im            (req_a_im),
      .req_b_re            (req_b_re),
      .req_b_im            (req_b_im),
      .req_bound           (req_bound),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_dist_res        (rsp_dist_res),
      .rsp_early_exit      (rsp_early_exit),
      .rsp_completed_count (rsp_completed_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_vector_length   (csr_vector_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #30_000_000;
      $display("FAIL bounded_complex_euclidean_distance");
      $finish;
   end

   // Squared difference of two signed Q1.15 samples, exact
   function automatic logic [SUM_W-1:0] diff_energy(logic [ELEM_W-1:0] x,
                                                   logic [ELEM_W-1:0] y);
      logic signed [DIFF_W-1:0] d;
      logic [SUM_W-1:0]         m;
      d = $signed({x[ELEM_W-1], x}) - $signed({y[ELEM_W-1], y});
      if (d < 0) begin
         d = -d;
      end
      m = {{(SUM_W-DIFF_W){1'b0}}, d};
      return m * m;
   endfunction

   // Floor square root, one result bit per trial from the top
   function automatic logic [DIST_W-1:0] floor_root(logic [SUM_W-1:0] v);
      logic [DIST_W-1:0] r;
      logic [DIST_W-1:0] trial;
      logic [SUM_W-1:0]  t;
      r = '0;
      for (int i = DIST_W - 1; i >= 0; i--) begin
         trial = r | (DIST_W'(1) << i);
         t = {{(SUM_W-DIST_W){1'b0}}, trial};
         if (t * t <= v) begin
            r = trial;
         end
      end
      return r;
   endfunction

   // Advance the predicted state by one accepted pair; queue any distance it yields
   function automatic void score_pair(pair_beat_type p);
      int unsigned     eff;
      int unsigned     count;
      logic            at_end;
      dist_result_type r;
      pairs_scored++;
      eff = cfg_len;
      if (eff < MIN_LEN) begin
         eff = MIN_LEN;
      end
      if (eff > DEF_MAX_LEN) begin
         eff = DEF_MAX_LEN;
      end
      // Latch the bound on the first element of a vector
      if (elem_idx == 0) begin
         acc_sum   = '0;
         limit_sq  = SUM_W'(p.bound) * SUM_W'(p.bound);
         abandoned = 1'b0;
      end
      if (!abandoned) begin
         acc_sum = acc_sum + diff_energy(p.a_re, p.b_re) + diff_energy(p.a_im, p.b_im);
      end
      count  = elem_idx + 1;
      at_end = (count >= eff);
      if (!abandoned && (count % DEF_BATCH_LEN) == 0 && acc_sum > limit_sq) begin
         r.root     = floor_root(acc_sum);
         r.early    = 1'b1;
         r.done_cnt = done_total;
         expected_dists.push_back(r);
         abandoned = 1'b1;
      end else if (!abandoned && at_end) begin
         done_total = done_total + 1;
         r.root     = floor_root(acc_sum);
         r.early    = 1'b0;
         r.done_cnt = done_total;
         expected_dists.push_back(r);
      end
      if (at_end) begin
         elem_idx  = '0;
         abandoned = 1'b0;
      end else begin
         elem_idx = LEN_W'(count);
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Result side: random stall, steady when asked
   always @(negedge clock) begin
      rsp_stall <= !steady_flow && ($urandom_range(99) < 30);
   end

   // Check each accepted result beat against the oldest prediction
   always @(posedge clock) begin
      dist_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dists.size() == 0) begin
            report_mismatch("unexpected result, dist_res", rsp_dist_res, -1);
         end else begin
            want = expected_dists.pop_front();
            if (rsp_dist_res !== want.root) begin
               report_mismatch("dist_res", rsp_dist_res, want.root);
            end
            if (rsp_early_exit !== want.early) begin
               report_mismatch("early_exit", rsp_early_exit, want.early);
            end
            if (rsp_completed_count !== want.done_cnt) begin
               report_mismatch("completed_count", rsp_completed_count, want.done_cnt);
            end
         end
      end
   end

   // Send one pair beat; called and returns on a falling edge
   task automatic send_pair(pair_beat_type p);
      if (!steady_flow && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_a_re  <= p.a_re;
      req_a_im  <= p.a_im;
      req_b_re  <= p.b_re;
      req_b_im  <= p.b_im;
      req_bound <= p.bound;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      score_pair(p);
      @(negedge clock);
   endtask

   // Drain the block, then write vector_length
   task automatic write_vector_length(int unsigned len);
      req_valid <= 1'b0;
      while (expected_dists.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid         <= 1'b1;
      csr_vector_length <= LEN_W'(len);
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      cfg_len = LEN_W'(len);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ELEM_W-1:0] rand_sample(bit quiet);
      if (quiet) begin
         return ELEM_W'($urandom_range(0, 512) - 256);
      end
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   // Bounds near the typical distance after one batch, plus the extremes
   function automatic logic [BOUND_W-1:0] pick_bound(bit quiet);
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return BOUND_W'($urandom);
         default: begin
            if (quiet) begin
               return BOUND_W'($urandom_range(1000, 6000));
            end
            return BOUND_W'($urandom_range(150000, 700000));
         end
      endcase
   endfunction

   // Send n pairs; the first carries the bound, later ones carry noise there
   task automatic send_vector(int unsigned n, logic [BOUND_W-1:0] lead_bound, bit quiet);
      pair_beat_type p;
      for (int unsigned i = 0; i < n; i++) begin
         p.a_re  = rand_sample(quiet);
         p.a_im  = rand_sample(quiet);
         p.b_re  = rand_sample(quiet);
         p.b_im  = rand_sample(quiet);
         p.bound = (i == 0) ? lead_bound : BOUND_W'($urandom);
         send_pair(p);
      end
   endtask

   // Reset length: one vector of extreme and corner samples
   task automatic test_default_length();
      send_pair('{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 24'd1});
      send_pair('{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 24'hABCDEF});
      send_pair('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000});
      send_pair('{16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 24'hFFFFFF});
      send_pair('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 24'h123456});
      send_pair('{16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 24'h654321});
      send_pair('{16'h1234, 16'hABCD, 16'hABCD, 16'h1234, 24'h5A5A5A});
      send_pair('{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 24'hA5A5A5});
   endtask

   // Shrink the length below the running element count, and below the minimum
   task automatic test_length_change();
      write_vector_length(16);
      send_vector(10, pick_bound(1'b0), 1'b0);
      write_vector_length(7);
      send_vector(1, pick_bound(1'b0), 1'b0);
   endtask

   // Bound exceeded mid-vector, then on the batch that is also the last element
   task automatic test_early_abandon();
      write_vector_length(2 * DEF_BATCH_LEN);
      send_vector(2 * DEF_BATCH_LEN, '0, 1'b0);
      write_vector_length(DEF_BATCH_LEN);
      send_vector(DEF_BATCH_LEN, 24'd1, 1'b0);
      send_vector(DEF_BATCH_LEN, '1, 1'b0);
   endtask

   // Length above max clamps and runs on; long vector abandoned and skipped
   task automatic test_max_length();
      write_vector_length((1 << LEN_W) - 1);
      for (int i = 0; i < 130; i++) begin
         send_pair('{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                     (i == 0) ? 24'hFFFFFF : BOUND_W'($urandom)});
      end
      write_vector_length(MIN_LEN);
      send_vector(1, '0, 1'b0);
      write_vector_length(DEF_MAX_LEN);
      send_vector(200, '0, 1'b0);
      write_vector_length(MIN_LEN);
      send_vector(1, '0, 1'b0);
   endtask

   function automatic int unsigned pick_length();
      case ($urandom_range(9))
         0: return $urandom_range(0, MIN_LEN - 1);
         1, 2, 3: return MIN_LEN * $urandom_range(1, 8);
         4: return $urandom_range(MIN_LEN + 1, 70);
         5: return DEF_BATCH_LEN;
         6: return 2 * DEF_BATCH_LEN;
         7: return $urandom_range(DEF_BATCH_LEN + 1, 250);
         default: return MIN_LEN * $urandom_range(15, 45);
      endcase
   endfunction

   // Random lengths and vectors, with partial vectors left open across writes
   task automatic test_random_vectors();
      int          start_pairs;
      int unsigned len;
      int unsigned eff;
      bit          quiet;
      start_pairs = pairs_scored;
      while (pairs_scored - start_pairs < RANDOM_PAIRS) begin
         len = pick_length();
         write_vector_length(len);
         steady_flow = (pairs_scored - start_pairs >= 300) &&
                       (pairs_scored - start_pairs < 700);
         eff = (len < MIN_LEN) ? MIN_LEN : len;
         repeat ($urandom_range(1, 3)) begin
            if (pairs_scored - start_pairs < RANDOM_PAIRS) begin
               quiet = 1'($urandom_range(1));
               send_vector(eff, pick_bound(quiet), quiet);
            end
         end
         if ($urandom_range(99) < 30) begin
            quiet = 1'($urandom_range(1));
            send_vector($urandom_range(1, (eff - 1 > 60) ? 60 : eff - 1),
                        pick_bound(quiet), quiet);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_a_re          = '0;
      req_a_im          = '0;
      req_b_re          = '0;
      req_b_im          = '0;
      req_bound         = '0;
      csr_valid         = 1'b0;
      csr_vector_length = '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_length();
      test_length_change();
      test_early_abandon();
      test_max_length();
      test_random_vectors();

      // Drop valid, wait out all results and the pipeline tail
      req_valid <= 1'b0;
      while (expected_dists.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS bounded_complex_euclidean_distance");
      end else begin
         $display("FAIL bounded_complex_euclidean_distance");
      end
      $finish;
   end

endmodule
